// ----- src/tbli_pkg.sv -----
// ----------------------------------------------------------------------------
// tbli_pkg: shared types and constants for the table interpolator
// Operation codes, controller states, the result bundle and the count clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package tbli_pkg;

  localparam int WL_W          = 32;
  localparam int FLUX_W        = 32;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int RESET_ENTRIES = 1024;
  localparam int DIV_STEPS     = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_BISECT,
    ST_LOAD_L,
    ST_LOAD_R,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tbli_state_t;

  typedef struct packed {
    logic [FLUX_W-1:0] flux;
    logic              oor;
  } tbli_res_t;

  // last usable index for a programmed entry count
  function automatic logic [31:0] clamp_last(input logic [31:0] count,
                                             input logic [31:0] depth);
    logic [31:0] n;
    n = count;
    if (n < 32'd2) n = 32'd2;
    if (n > depth) n = depth;
    return n - 32'd1;
  endfunction

endpackage

`default_nettype wire

// ----- src/tbli_mem.sv -----
// ----------------------------------------------------------------------------
// tbli_mem: breakpoint storage
// Wavelength and flux arrays sharing one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tbli_mem #(
  parameter int DEPTH = tbli_pkg::DEF_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [tbli_pkg::WL_W-1:0]   wr_wave,
  input  wire logic [tbli_pkg::FLUX_W-1:0] wr_flux,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [tbli_pkg::WL_W-1:0]   rd_wave,
  output logic      [tbli_pkg::FLUX_W-1:0] rd_flux
);

  logic [tbli_pkg::WL_W-1:0]   wave_mem [DEPTH];
  logic [tbli_pkg::FLUX_W-1:0] flux_mem [DEPTH];
  logic [tbli_pkg::WL_W-1:0]   rd_wave_r;
  logic [tbli_pkg::FLUX_W-1:0] rd_flux_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem[wr_addr] <= wr_wave;
      flux_mem[wr_addr] <= wr_flux;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_wave_r <= wave_mem[rd_addr];
      rd_flux_r <= flux_mem[rd_addr];
    end
  end

  assign rd_wave = rd_wave_r;
  assign rd_flux = rd_flux_r;

endmodule

`default_nettype wire

// ----- src/tbli_div.sv -----
// ----------------------------------------------------------------------------
// tbli_div: serial restoring divider
// 64 by 32 bit division, one quotient bit a cycle; the caller guarantees the
// quotient fits 32 bits (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module tbli_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic      [31:0] quotient
);

  localparam int CW = $clog2(tbli_pkg::DIV_STEPS + 1);

  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [31:0]   dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   trial;
  logic          ge;

  always_comb begin
    trial    = {rem_r, quo_r[31]};
    ge       = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[63:32];
      quo_nxt  = dividend[31:0];
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(tbli_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below divisor, so the difference fits 32 bits
      rem_nxt = ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- src/tbli_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbli_ctrl: query sequencer
// Bound checks, bisection over the table memory, bracket load and the
// interpolation arithmetic around the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tbli_ctrl #(
  parameter int AW = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        query_start,
  input  wire logic [tbli_pkg::WL_W-1:0]   query_wl,
  input  wire logic [AW-1:0]               last_idx,
  output logic                             idle,
  output logic                             rd_en,
  output logic      [AW-1:0]               rd_addr,
  input  wire logic [tbli_pkg::WL_W-1:0]   rd_wave,
  input  wire logic [tbli_pkg::FLUX_W-1:0] rd_flux,
  output logic                             div_start,
  output logic      [63:0]                 div_dividend,
  output logic      [31:0]                 div_divisor,
  input  wire logic                        div_busy,
  input  wire logic                        div_done,
  input  wire logic [31:0]                 div_quotient,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output tbli_pkg::tbli_res_t              res
);

  tbli_pkg::tbli_state_t state_r, state_nxt;

  logic [tbli_pkg::WL_W-1:0]   q_r, q_nxt;
  logic [AW-1:0]               lo_r, lo_nxt;
  logic [AW-1:0]               hi_r, hi_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;
  logic [tbli_pkg::WL_W-1:0]   w0_r, w0_nxt;
  logic [tbli_pkg::FLUX_W-1:0] f0_r, f0_nxt;
  logic [tbli_pkg::WL_W-1:0]   off_r, off_nxt;
  logic [tbli_pkg::WL_W-1:0]   d_r, d_nxt;
  logic [tbli_pkg::FLUX_W-1:0] diff_r, diff_nxt;
  logic                        up_r, up_nxt;
  tbli_pkg::tbli_res_t         res_r, res_nxt;

  // bisection helpers
  logic          ge_mid;
  logic [AW-1:0] mid0, mid_up, mid_dn, mid_b, lo_b, hi_b;
  logic          more0, more_b;
  logic [tbli_pkg::WL_W-1:0] d_new;

  always_comb begin
    ge_mid = q_r >= rd_wave;
    mid0   = AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
    more0  = (hi_r - lo_r) > AW'(1);
    mid_up = AW'(({1'b0, mid_r} + {1'b0, hi_r}) >> 1);
    mid_dn = AW'(({1'b0, lo_r} + {1'b0, mid_r}) >> 1);
    lo_b   = ge_mid ? mid_r : lo_r;
    hi_b   = ge_mid ? hi_r : mid_r;
    mid_b  = ge_mid ? mid_up : mid_dn;
    more_b = ge_mid ? ((hi_r - mid_r) > AW'(1)) : ((mid_r - lo_r) > AW'(1));
    d_new  = rd_wave - w0_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbli_pkg::ST_IDLE:   if (query_start) state_nxt = tbli_pkg::ST_CHK_LO;
      tbli_pkg::ST_CHK_LO: begin
        state_nxt = (q_r < rd_wave) ? tbli_pkg::ST_DONE : tbli_pkg::ST_CHK_HI;
      end
      tbli_pkg::ST_CHK_HI: begin
        priority if (q_r > rd_wave) state_nxt = tbli_pkg::ST_DONE;
        else if (more0)             state_nxt = tbli_pkg::ST_BISECT;
        else                        state_nxt = tbli_pkg::ST_LOAD_L;
      end
      tbli_pkg::ST_BISECT: if (!more_b) state_nxt = tbli_pkg::ST_LOAD_L;
      tbli_pkg::ST_LOAD_L: state_nxt = tbli_pkg::ST_LOAD_R;
      tbli_pkg::ST_LOAD_R: begin
        state_nxt = (rd_wave > w0_r) ? tbli_pkg::ST_MUL : tbli_pkg::ST_DONE;
      end
      tbli_pkg::ST_MUL:    state_nxt = tbli_pkg::ST_DIV;
      tbli_pkg::ST_DIV:    if (div_done) state_nxt = tbli_pkg::ST_DONE;
      tbli_pkg::ST_DONE:   if (res_ready) state_nxt = tbli_pkg::ST_IDLE;
      default:             state_nxt = tbli_pkg::ST_IDLE;
    endcase
  end

  // memory, divider and result strobes
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = lo_r;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      tbli_pkg::ST_IDLE: begin
        rd_en   = query_start;
        rd_addr = '0;
      end
      tbli_pkg::ST_CHK_LO: begin
        rd_en   = 1'b1;
        rd_addr = hi_r;
      end
      tbli_pkg::ST_CHK_HI: begin
        rd_en   = 1'b1;
        rd_addr = more0 ? mid0 : lo_r;
      end
      tbli_pkg::ST_BISECT: begin
        rd_en   = 1'b1;
        rd_addr = more_b ? mid_b : lo_b;
      end
      tbli_pkg::ST_LOAD_L: begin
        rd_en   = 1'b1;
        rd_addr = AW'(lo_r + AW'(1));
      end
      tbli_pkg::ST_MUL:  div_start = 1'b1;
      tbli_pkg::ST_DONE: res_valid = 1'b1;
      tbli_pkg::ST_LOAD_R, tbli_pkg::ST_DIV: begin
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    q_nxt    = q_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    w0_nxt   = w0_r;
    f0_nxt   = f0_r;
    off_nxt  = off_r;
    d_nxt    = d_r;
    diff_nxt = diff_r;
    up_nxt   = up_r;
    res_nxt  = res_r;
    unique case (state_r)
      tbli_pkg::ST_IDLE: begin
        q_nxt  = query_wl;
        lo_nxt = '0;
        hi_nxt = last_idx;
      end
      tbli_pkg::ST_CHK_LO: begin
        res_nxt.flux = '0;
        res_nxt.oor  = 1'b1;
      end
      tbli_pkg::ST_CHK_HI: begin
        res_nxt.flux = '0;
        res_nxt.oor  = 1'b1;
        mid_nxt      = mid0;
      end
      tbli_pkg::ST_BISECT: begin
        lo_nxt  = lo_b;
        hi_nxt  = hi_b;
        mid_nxt = mid_b;
      end
      tbli_pkg::ST_LOAD_L: begin
        w0_nxt  = rd_wave;
        f0_nxt  = rd_flux;
        off_nxt = (q_r >= rd_wave) ? (q_r - rd_wave) : '0;
      end
      tbli_pkg::ST_LOAD_R: begin
        // non-ascending or zero-width interval returns the left flux
        d_nxt        = d_new;
        off_nxt      = (off_r > d_new) ? d_new : off_r;
        up_nxt       = rd_flux >= f0_r;
        diff_nxt     = (rd_flux >= f0_r) ? (rd_flux - f0_r) : (f0_r - rd_flux);
        res_nxt.flux = f0_r;
        res_nxt.oor  = 1'b0;
      end
      tbli_pkg::ST_DIV: begin
        if (div_done) begin
          res_nxt.flux = up_r ? (f0_r + div_quotient) : (f0_r - div_quotient);
          res_nxt.oor  = 1'b0;
        end
      end
      tbli_pkg::ST_MUL, tbli_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    w0_r   <= w0_nxt;
    f0_r   <= f0_nxt;
    off_r  <= off_nxt;
    d_r    <= d_nxt;
    diff_r <= diff_nxt;
    up_r   <= up_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      state_r <= tbli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle         = (state_r == tbli_pkg::ST_IDLE);
  assign div_dividend = 64'(diff_r) * 64'(off_r);
  assign div_divisor  = d_r;
  assign res          = res_r;

  // probe stays strictly inside the bracket
  ap_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbli_pkg::ST_BISECT) |-> ((mid_r > lo_r) && (mid_r < hi_r)))
    else $error("bisection probe outside bracket");

  ap_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  ap_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbli_pkg::ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  ap_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_r)))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire

// ----- src/table_bisect_linear_interp.sv -----
// ----------------------------------------------------------------------------
// table_bisect_linear_interp: breakpoint table with bisection and lerp
// Loads ascending wavelength/flux breakpoints and answers wavelength queries
// with a linearly interpolated flux, or an out-of-range flag and zero.
//
//   channel | direction | handshake           | beat
//   in_     | input     | in_valid/in_stall   | write entry or query
//   out_    | output    | out_valid/out_stall | flux, out_of_range
//   cfg_    | input     | cfg_wr_en           | entries_in_use
//
// A query makes one table read per bisection step on the single read port,
// then, for an ascending interval, runs the bit-serial divider.
// Reset clears the sequencer and sets entries_in_use to 1024; table
// contents are undefined until written, so there is no clearing pass.
// in_stall is high while a query is in flight; a finished result sits in
// the output register under out_stall while the next beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module table_bisect_linear_interp #(
  parameter int TABLE_DEPTH = tbli_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_operation,
  input  wire logic [tbli_pkg::IDX_W-1:0]  in_entry_index,
  input  wire logic [tbli_pkg::WL_W-1:0]   in_entry_wavelength,
  input  wire logic [tbli_pkg::FLUX_W-1:0] in_entry_flux,
  input  wire logic [tbli_pkg::WL_W-1:0]   in_query_wavelength,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [tbli_pkg::FLUX_W-1:0] out_flux,
  output logic                             out_out_of_range,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tbli_pkg::CNT_W-1:0]  cfg_entries_in_use
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [AW-1:0] last_r, last_nxt;
  logic          accept, wr_en, query_start, ctrl_idle;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [tbli_pkg::WL_W-1:0]   rd_wave;
  logic [tbli_pkg::FLUX_W-1:0] rd_flux;
  logic          div_start, div_busy, div_done;
  logic [63:0]   div_dividend;
  logic [31:0]   div_divisor, div_quotient;
  logic          res_valid, res_ready;
  tbli_pkg::tbli_res_t res;

  logic                        out_valid_r, out_valid_nxt;
  logic [tbli_pkg::FLUX_W-1:0] out_flux_r;
  logic                        out_oor_r;

  assign in_stall    = !ctrl_idle;
  assign accept      = in_valid && !in_stall;
  assign wr_en       = accept && (in_operation == tbli_pkg::OP_WRITE) &&
                       (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign query_start = accept && (in_operation == tbli_pkg::OP_QUERY);

  // entry count kept as the clamped last index
  always_comb begin
    last_nxt = last_r;
    if (cfg_wr_en) begin
      last_nxt = AW'(tbli_pkg::clamp_last(32'(cfg_entries_in_use), 32'(TABLE_DEPTH)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= AW'(tbli_pkg::clamp_last(32'(tbli_pkg::RESET_ENTRIES), 32'(TABLE_DEPTH)));
    end else begin
      last_r <= last_nxt;
    end
  end

  tbli_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_wave (in_entry_wavelength),
    .wr_flux (in_entry_flux),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_wave (rd_wave),
    .rd_flux (rd_flux)
  );

  tbli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  tbli_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_start  (query_start),
    .query_wl     (in_query_wavelength),
    .last_idx     (last_r),
    .idle         (ctrl_idle),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_wave      (rd_wave),
    .rd_flux      (rd_flux),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_flux_r <= res.flux;
      out_oor_r  <= res.oor;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_flux         = out_flux_r;
  assign out_out_of_range = out_oor_r;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for table_bisect_linear_interp
// Loads breakpoint tables, sends wavelength queries and table writes under
// random input gaps and output stalls, and checks every returned flux and
// range flag against a bisection / interpolation predictor kept in step.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   WL_W            = tbli_pkg::WL_W;
  localparam int   FLUX_W          = tbli_pkg::FLUX_W;
  localparam int   IDX_W           = tbli_pkg::IDX_W;
  localparam int   CNT_W           = tbli_pkg::CNT_W;
  localparam int   DEF_TABLE_DEPTH = tbli_pkg::DEF_TABLE_DEPTH;
  localparam int   RESET_ENTRIES   = tbli_pkg::RESET_ENTRIES;
  localparam logic OP_WRITE        = tbli_pkg::OP_WRITE;
  localparam logic OP_QUERY        = tbli_pkg::OP_QUERY;

  typedef tbli_pkg::tbli_res_t tbli_res_t;

  localparam int QUIET_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_operation;
  logic [IDX_W-1:0]    in_entry_index;
  logic [WL_W-1:0]     in_entry_wavelength;
  logic [FLUX_W-1:0]   in_entry_flux;
  logic [WL_W-1:0]     in_query_wavelength;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FLUX_W-1:0]   out_flux;
  logic                out_out_of_range;
  logic                cfg_wr_en;
  logic [CNT_W-1:0]    cfg_entries_in_use;

  // predictor state: breakpoint tables and the programmed entry count
  logic [WL_W-1:0]     bp_wl   [0:DEF_TABLE_DEPTH-1];
  logic [FLUX_W-1:0]   bp_flux [0:DEF_TABLE_DEPTH-1];
  logic [CNT_W-1:0]    bp_count = CNT_W'(RESET_ENTRIES);
  tbli_res_t           flux_expected[$];

  int                  errors = 0;
  int unsigned         cycles = 0;
  bit                  idle_in = 1'b1;
  bit                  idle_out = 1'b1;
  int unsigned         stall_left = 0;

  table_bisect_linear_interp dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_entry_index      (in_entry_index),
    .in_entry_wavelength (in_entry_wavelength),
    .in_entry_flux       (in_entry_flux),
    .in_query_wavelength (in_query_wavelength),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flux            (out_flux),
    .out_out_of_range    (out_out_of_range),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_entries_in_use  (cfg_entries_in_use)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // output stall in random bursts, only while idle_out is set
  always @(posedge clk) begin
    if (!idle_out) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned searched_entries();
    int unsigned n;
    n = 32'(bp_count);
    if (n < 2) n = 2;
    if (n > DEF_TABLE_DEPTH) n = DEF_TABLE_DEPTH;
    return n;
  endfunction

  function automatic tbli_res_t interp_flux(input logic [WL_W-1:0] q);
    int unsigned n, lo, hi, mid;
    logic [WL_W-1:0]   w0, w1, d, off;
    logic [FLUX_W-1:0] f0, f1;
    logic [63:0]       mag;
    tbli_res_t         r;
    n = searched_entries();
    r.flux = '0;
    r.oor = 1'b0;
    if (q < bp_wl[0] || q > bp_wl[n-1]) begin
      r.oor = 1'b1;
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (q >= bp_wl[mid]) lo = mid;
      else hi = mid;
    end
    w0 = bp_wl[lo];
    w1 = bp_wl[lo+1];
    f0 = bp_flux[lo];
    f1 = bp_flux[lo+1];
    // zero-width or descending interval keeps the left flux
    if (w1 <= w0) begin
      r.flux = f0;
      return r;
    end
    d = w1 - w0;
    off = (q >= w0) ? q - w0 : '0;
    if (off > d) off = d;
    if (f1 >= f0) begin
      mag = ({32'd0, f1 - f0} * {32'd0, off}) / {32'd0, d};
      r.flux = f0 + mag[FLUX_W-1:0];
    end else begin
      mag = ({32'd0, f0 - f1} * {32'd0, off}) / {32'd0, d};
      r.flux = f0 - mag[FLUX_W-1:0];
    end
    return r;
  endfunction

  task automatic flag_error(input string what, input tbli_res_t want, input tbli_res_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected flux %h oor %b, got flux %h oor %b",
               what, want.flux, want.oor, got.flux, got.oor);
  endtask

  always @(posedge clk) begin
    tbli_res_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got.flux = out_flux;
      got.oor = out_out_of_range;
      if (flux_expected.size() == 0) begin
        flag_error("unexpected result beat", '0, got);
      end else begin
        want = flux_expected.pop_front();
        if (want.flux !== got.flux || want.oor !== got.oor)
          flag_error("lookup mismatch", want, got);
      end
    end
  end

  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [WL_W-1:0] wl, input logic [FLUX_W-1:0] fx,
                           input logic [WL_W-1:0] q);
    if (idle_in && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_entry_index      <= idx;
    in_entry_wavelength <= wl;
    in_entry_flux       <= fx;
    in_query_wavelength <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_WRITE) begin
      bp_wl[idx] = wl;
      bp_flux[idx] = fx;
    end else begin
      flux_expected.push_back(interp_flux(q));
    end
  endtask

  task automatic send_query(input logic [WL_W-1:0] q);
    send_beat(OP_QUERY, IDX_W'($urandom()), $urandom(), $urandom(), q);
  endtask

  // only while idle: drain results, let a trailing write settle, then write
  task automatic program_entries(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (flux_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_entries_in_use <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bp_count = value;
  endtask

  task automatic load_ascending_table(input int unsigned count);
    logic [WL_W-1:0] span, wl, step_max;
    int unsigned i;
    span = $urandom() >> $urandom_range(0, 28);
    wl = $urandom_range(0, 32'hFFFF_FFFF - span);
    step_max = span / count;
    for (i = 0; i < count; i++) begin
      send_beat(OP_WRITE, IDX_W'(i), wl, $urandom(), $urandom());
      // occasional repeated wavelength gives zero-width intervals
      if (step_max != 0 && $urandom_range(0, 15) != 0)
        wl += $urandom_range(1, step_max);
    end
  endtask

  task automatic random_query(input int unsigned n);
    logic [WL_W-1:0] q, lo_w, hi_w;
    int unsigned k;
    case ($urandom_range(0, 9))
      0: q = $urandom();
      1: q = bp_wl[$urandom_range(0, n - 1)];
      2: q = bp_wl[0] - 1 - $urandom_range(0, 3);
      3: q = bp_wl[n-1] + 1 + $urandom_range(0, 3);
      default: begin
        k = $urandom_range(0, n - 2);
        lo_w = bp_wl[k];
        hi_w = bp_wl[k+1];
        q = (hi_w > lo_w) ? $urandom_range(lo_w, hi_w) : lo_w;
      end
    endcase
    send_query(q);
  endtask

  task automatic random_item(input int unsigned n);
    int unsigned pick, k;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // new flux at an existing breakpoint keeps the table ascending
      k = $urandom_range(0, n - 1);
      send_beat(OP_WRITE, IDX_W'(k), bp_wl[k], $urandom(), $urandom());
    end else if (pick < 20) begin
      send_beat(OP_WRITE, IDX_W'($urandom()), $urandom(), $urandom(), $urandom());
    end else begin
      random_query(n);
    end
  endtask

  task automatic test_reset_entry_count();
    int unsigned i;
    load_ascending_table(DEF_TABLE_DEPTH);
    send_query(32'h0000_0000);
    send_query(32'hFFFF_FFFF);
    for (i = 0; i < 100; i++) random_item(DEF_TABLE_DEPTH);
  endtask

  task automatic test_count_clamp_high();
    int unsigned i;
    program_entries({CNT_W{1'b1}});
    for (i = 0; i < 60; i++) random_item(searched_entries());
  endtask

  task automatic test_directed_corners();
    program_entries('0);
    send_beat(OP_WRITE, 10'd0, 32'h0000_0100, 32'h0000_0000, 32'h0);
    send_beat(OP_WRITE, 10'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_query(32'h0000_0000);
    send_query(32'h0000_0100);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFF);
    // falling flux
    send_beat(OP_WRITE, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
    send_beat(OP_WRITE, 10'd1, 32'h0000_1000, 32'h0000_0000, 32'h0);
    send_query(32'h0000_0800);
    send_query(32'h0000_1001);
    // zero-width interval
    send_beat(OP_WRITE, 10'd1, 32'h0000_0000, 32'h0000_0005, 32'h0);
    send_query(32'h0000_0000);
    // hit on a repeated last breakpoint lands in the zero-width interval
    program_entries(11'd3);
    send_beat(OP_WRITE, 10'd0, 32'd10, 32'd100, 32'h0);
    send_beat(OP_WRITE, 10'd1, 32'd80, 32'd200, 32'h0);
    send_beat(OP_WRITE, 10'd2, 32'd80, 32'd300, 32'h0);
    send_query(32'd80);
    send_query(32'd45);
    // count below two, then a descending table
    program_entries(11'd1);
    send_query(32'd80);
    send_beat(OP_WRITE, 10'd1, 32'd5, 32'd7, 32'h0);
    send_query(32'd7);
    send_query(32'd10);
  endtask

  task automatic test_random_tables();
    int unsigned p, i, n;
    for (p = 0; p < 5; p++) begin
      program_entries((p == 0) ? 11'd2 : CNT_W'($urandom_range(4, 48)));
      n = searched_entries();
      load_ascending_table(n);
      for (i = 0; i < 70; i++) random_item(n);
    end
  endtask

  task automatic test_back_to_back();
    int unsigned i, n;
    program_entries(CNT_W'($urandom_range(2, 64)));
    idle_in = 1'b0;
    idle_out = 1'b0;
    n = searched_entries();
    load_ascending_table(n);
    for (i = 0; i < 100; i++) random_item(n);
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_operation        <= OP_WRITE;
    in_entry_index      <= '0;
    in_entry_wavelength <= '0;
    in_entry_flux       <= '0;
    in_query_wavelength <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_entries_in_use  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_entry_count();
    test_count_clamp_high();
    test_directed_corners();
    test_random_tables();
    test_back_to_back();

    in_valid <= 1'b0;
    while (flux_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
